>>> rtl/blr_pkg.sv
package blr_pkg;

  localparam int COORD_W = 6;
  localparam int COLOR_W = 24;

  typedef struct packed {
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic [COORD_W-1:0] end_x;
    logic [COORD_W-1:0] end_y;
  } line_cmd_t;

  typedef struct packed {
    logic [COORD_W-1:0] pixel_x;
    logic [COORD_W-1:0] pixel_y;
    logic [COLOR_W-1:0] pixel_color;
    logic               last_pixel;
  } pixel_t;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_DRAW = 2'b10
  } state_t;

  typedef struct packed {
    logic load;
    logic step;
  } ctl_cmd_t;

  typedef struct packed {
    logic last;
  } dp_status_t;

endpackage

>>> rtl/blr_ctrl.sv
module blr_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  blr_pkg::dp_status_t status,
  output blr_pkg::ctl_cmd_t   cmd,
  output logic               busy,
  output logic               out_strobe
);

  blr_pkg::state_t state_r, state_nxt;
  logic            strobe_r, strobe_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd.load  = 1'b0;
    cmd.step  = 1'b0;
    unique case (state_r)
      blr_pkg::ST_IDLE: begin
        if (start) begin
          cmd.load  = 1'b1;
          state_nxt = blr_pkg::ST_DRAW;
        end
      end
      blr_pkg::ST_DRAW: begin
        cmd.step = 1'b1;
        if (status.last) begin
          state_nxt = blr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = blr_pkg::ST_IDLE;
      end
    endcase
  end

  assign strobe_nxt = cmd.step;
  assign busy       = (state_r != blr_pkg::ST_IDLE);
  assign out_strobe = strobe_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= blr_pkg::ST_IDLE;
      strobe_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      strobe_r <= strobe_nxt;
    end
  end

  a_busy_ends_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) && $past(rst_n) |-> $past(status.last))
    else $error("Drawing ended before the last pixel.");

  a_strobe_follows_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $past(cmd.step) |-> strobe_r)
    else $error("A drawn pixel produced no strobe.");

endmodule

>>> rtl/blr_datapath.sv
module blr_datapath #(
  parameter int COORD_BITS = 6
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  blr_pkg::ctl_cmd_t            cmd,
  input  blr_pkg::line_cmd_t           line_cmd,
  input  logic [blr_pkg::COLOR_W-1:0]  color,
  output blr_pkg::dp_status_t          status,
  output blr_pkg::pixel_t              pixel
);

  localparam int W  = COORD_BITS;
  localparam int EW = COORD_BITS + 3;

  logic [W-1:0] ax, ay, bx, by;
  logic [W-1:0] adx, ady, major, minor;
  logic         steep, swap;
  logic [W-1:0] x0, y0, ex, ey;
  logic signed [EW-1:0] major_e, minor_e;

  logic [W-1:0]         x_r, x_nxt;
  logic [W-1:0]         y_r, y_nxt;
  logic [W-1:0]         cnt_r, cnt_nxt;
  logic signed [EW-1:0] err_r, err_nxt;
  logic signed [EW-1:0] inc_lt_r, inc_lt_nxt;
  logic signed [EW-1:0] inc_ge_r, inc_ge_nxt;
  logic                 steep_r, steep_nxt;
  logic                 neg_r, neg_nxt;
  blr_pkg::pixel_t      pixel_r, pixel_nxt;
  logic [W-1:0]         minor_step;

  assign ax = line_cmd.start_x[W-1:0];
  assign ay = line_cmd.start_y[W-1:0];
  assign bx = line_cmd.end_x[W-1:0];
  assign by = line_cmd.end_y[W-1:0];

  assign adx   = (bx > ax) ? bx - ax : ax - bx;
  assign ady   = (by > ay) ? by - ay : ay - by;
  assign steep = (adx == '0) || (ady > adx);
  assign swap  = steep ? (ay > by) : (ax > bx);
  assign x0    = swap ? bx : ax;
  assign y0    = swap ? by : ay;
  assign ex    = swap ? ax : bx;
  assign ey    = swap ? ay : by;
  assign major = steep ? ady : adx;
  assign minor = steep ? adx : ady;

  assign major_e = EW'(major);
  assign minor_e = EW'(minor);

  assign minor_step = neg_r ? {W{1'b1}} : W'(1);

  always_comb begin
    x_nxt      = x_r;
    y_nxt      = y_r;
    cnt_nxt    = cnt_r;
    err_nxt    = err_r;
    inc_lt_nxt = inc_lt_r;
    inc_ge_nxt = inc_ge_r;
    steep_nxt  = steep_r;
    neg_nxt    = neg_r;
    pixel_nxt  = pixel_r;
    if (cmd.load) begin
      x_nxt      = x0;
      y_nxt      = y0;
      cnt_nxt    = major;
      err_nxt    = (minor_e <<< 1) - major_e;
      inc_lt_nxt = minor_e <<< 1;
      inc_ge_nxt = (minor_e <<< 1) - (major_e <<< 1);
      steep_nxt  = steep;
      neg_nxt    = steep ? (ex < x0) : (ey < y0);
    end else if (cmd.step) begin
      pixel_nxt.pixel_x     = blr_pkg::COORD_W'(x_r);
      pixel_nxt.pixel_y     = blr_pkg::COORD_W'(y_r);
      pixel_nxt.pixel_color = color;
      pixel_nxt.last_pixel  = (cnt_r == '0);
      cnt_nxt = cnt_r - W'(1);
      if (steep_r) begin
        y_nxt = y_r + W'(1);
      end else begin
        x_nxt = x_r + W'(1);
      end
      if (err_r < 0) begin
        err_nxt = err_r + inc_lt_r;
      end else begin
        err_nxt = err_r + inc_ge_r;
        if (steep_r) begin
          x_nxt = x_r + minor_step;
        end else begin
          y_nxt = y_r + minor_step;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    x_r      <= x_nxt;
    y_r      <= y_nxt;
    cnt_r    <= cnt_nxt;
    err_r    <= err_nxt;
    inc_lt_r <= inc_lt_nxt;
    inc_ge_r <= inc_ge_nxt;
    steep_r  <= steep_nxt;
    neg_r    <= neg_nxt;
    pixel_r  <= pixel_nxt;
  end

  assign status.last = (cnt_r == '0);
  assign pixel       = pixel_r;

  a_count_down: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step && !status.last |=> cnt_r == $past(cnt_r) - W'(1))
    else $error("Pixel count did not advance by one.");

  a_major_axis_moves: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step && steep_r |=> y_r == $past(y_r) + W'(1))
    else $error("Steep line did not advance along y.");

endmodule

>>> rtl/bresenham_line_raster.sv
// The accepting edge loads the datapath; ST_DRAW then registers the first pixel.
// A line of N pixels (N = max(|dx|,|dy|)+1, at most 64) comes one pixel per cycle
// from the stepping datapath; a new command is accepted only while idle.
// Reset (rst_n low at a clock edge) abandons any line, clears the strobe and sets color to 0.
// The receiver cannot stall; every strobed pixel is a completed transaction.
module bresenham_line_raster #(
  parameter int COORD_BITS = 6
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  blr_pkg::line_cmd_t           in_cmd,
  output logic                         out_strobe,
  output blr_pkg::pixel_t              out_pixel,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [blr_pkg::COLOR_W-1:0]  cfg_data
);

  blr_pkg::ctl_cmd_t   cmd;
  blr_pkg::dp_status_t status;
  logic [blr_pkg::COLOR_W-1:0] color_r, color_nxt;

  assign cfg_ready = 1'b1;
  assign color_nxt = (cfg_valid && cfg_ready) ? cfg_data : color_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_r <= '0;
    end else begin
      color_r <= color_nxt;
    end
  end

  blr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .status     (status),
    .cmd        (cmd),
    .busy       (busy),
    .out_strobe (out_strobe)
  );

  blr_datapath #(
    .COORD_BITS (COORD_BITS)
  ) u_datapath (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .line_cmd (in_cmd),
    .color    (color_r),
    .status   (status),
    .pixel    (out_pixel)
  );

  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_pixel.last_pixel |=> !out_strobe)
    else $error("Pixel strobed right after the last pixel of a line.");

  a_no_accept_while_drawing: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_pixel.last_pixel |-> busy)
    else $error("Block idle in the middle of a line.");

endmodule
